// ===== src/infix_to_postfix_converter_core_defines.svh =====
// Assertion macros used by the checker file of the infix-to-postfix core.
// No dependencies; the user must provide clk_i and rst_ni in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

// Checked at every edge, also while reset is held.
`define IFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked only outside reset.
`define IFP_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ===== src/ifp_pkg.sv =====
// Shared types, character codes and precedence functions for the
// infix-to-postfix core. No dependencies.
`default_nettype none

package ifp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CHR_POW    = 8'h24;  // '$'
  localparam logic [7:0] CHR_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CHR_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CHR_MUL    = 8'h2A;  // '*'
  localparam logic [7:0] CHR_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CHR_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CHR_DIV    = 8'h2F;  // '/'
  localparam logic [7:0] CHR_UPPER_A = 8'd65;
  localparam logic [7:0] CHR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHR_DIGIT_0 = 8'd48;
  localparam logic [7:0] CHR_DIGIT_9 = 8'd57;
  localparam logic [7:0] CHR_LOWER_A = 8'd97;
  localparam logic [7:0] CHR_LOWER_Z = 8'd122;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_terminator;
    logic       overflow;
    logic       last;
  } result_t;

  function automatic logic is_operand(input logic [7:0] c);
    is_operand = (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) ||
                 (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) ||
                 (c >= CHR_LOWER_A && c <= CHR_LOWER_Z);
  endfunction

  // True when the stacked top must be emitted before c is handled.
  function automatic logic should_pop(input logic [7:0] top, input logic [7:0] c);
    if (top == CHR_LPAREN || c == CHR_LPAREN) begin
      should_pop = 1'b0;
    end else if (c == CHR_RPAREN) begin
      should_pop = 1'b1;
    end else if (top == CHR_POW && c == CHR_POW) begin
      should_pop = 1'b0;
    end else if (top == c) begin
      should_pop = 1'b1;
    end else if (top == CHR_POW) begin
      should_pop = 1'b1;
    end else if ((top == CHR_MUL || top == CHR_DIV) && c != CHR_POW) begin
      should_pop = 1'b1;
    end else begin
      should_pop = (top == CHR_PLUS && c == CHR_MINUS) ||
                   (top == CHR_MINUS && c == CHR_PLUS);
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/ifp_stack_mem.sv =====
// Operator stack storage: one write port, one registered read port, with
// write-to-read forwarding. No package dependencies.
`default_nettype none

module ifp_stack_mem #(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem_q [STACK_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A push writes the entry that becomes the new top in the same cycle,
  // so that word is forwarded into the read register.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_addr_i == rd_addr_i) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/ifp_ctrl.sv =====
// Sequencer of the infix-to-postfix core: stack count, overflow flag,
// pending pop word and push/pop decisions. Depends on ifp_pkg.
`default_nettype none

module ifp_ctrl #(
  parameter int unsigned STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STACK_DEPTH),
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             in_end_i,
  input  wire logic [7:0]       in_symbol_i,
  output logic                  emit_valid_o,
  output ifp_pkg::result_t      emit_o,
  input  wire logic             emit_free_i,
  output logic                  wr_en_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [7:0]            wr_data_o,
  output logic [AW-1:0]         rd_addr_o,
  input  wire logic [7:0]       top_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          pend_vld_q, pend_vld_d;
  logic [7:0]    pend_q, pend_d;
  logic          end_q;
  logic [7:0]    sym_q;
  logic          pop_ok;
  logic          go;
  logic [CW-1:0] count_m1;

  assign in_ready_o = (state_q == ST_IDLE);
  assign pop_ok = (count_q != '0) && ifp_pkg::should_pop(top_i, sym_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    emit_valid_o = 1'b0;
    emit_o       = '{out_char: pend_q, is_terminator: 1'b0, overflow: ovf_q, last: 1'b0};
    wr_en_o      = 1'b0;
    wr_addr_o    = count_q[AW-1:0];
    wr_data_o    = sym_q;
    go           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (end_q) begin
          emit_valid_o = 1'b1;
          if (count_q != '0) begin
            emit_o.out_char = top_i;
            if (emit_free_i) begin
              count_d = count_q - CW'(1);
            end
          end else begin
            emit_o = '{out_char: 8'h00, is_terminator: 1'b1, overflow: ovf_q, last: 1'b1};
            if (emit_free_i) begin
              ovf_d   = 1'b0;
              state_d = ST_IDLE;
            end
          end
        end else if (ifp_pkg::is_operand(sym_q)) begin
          emit_valid_o    = 1'b1;
          emit_o.out_char = sym_q;
          emit_o.last     = 1'b1;
          if (emit_free_i) begin
            state_d = ST_IDLE;
          end
        end else if (pop_ok) begin
          // The held word is not the last one: another pop follows it.
          emit_valid_o = pend_vld_q;
          go = !pend_vld_q || emit_free_i;
          if (go) begin
            pend_d     = top_i;
            pend_vld_d = 1'b1;
            count_d    = count_q - CW'(1);
          end
        end else begin
          emit_valid_o = pend_vld_q;
          emit_o.last  = 1'b1;
          go = !pend_vld_q || emit_free_i;
          if (go) begin
            pend_vld_d = 1'b0;
            state_d    = ST_IDLE;
            if (count_q == '0 || sym_q != ifp_pkg::CHR_RPAREN) begin
              if (count_q < CW'(STACK_DEPTH)) begin
                wr_en_o = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end else begin
              // Drop the matching open parenthesis.
              count_d = count_q - CW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The read port always fetches the top of the stack as it will stand
  // next cycle.
  assign count_m1  = count_d - CW'(1);
  assign rd_addr_o = (count_d == '0) ? '0 : count_m1[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_valid_i && in_ready_o) begin
      end_q <= in_end_i;
      sym_q <= in_symbol_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/ifp_out_reg.sv =====
// Output register of the infix-to-postfix core, holds one result word for
// the downstream stream. Depends on ifp_pkg.
`default_nettype none

module ifp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_valid_i,
  input  wire ifp_pkg::result_t  load_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [7:0]             m_axis_tdata_o,
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  logic             vld_q;
  ifp_pkg::result_t res_q;

  assign free_o = !vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_valid_i) begin
      res_q <= load_i;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = res_q.out_char;
  assign m_axis_tuser_o  = {res_q.overflow, res_q.is_terminator};
  assign m_axis_tlast_o  = res_q.last;

endmodule

`default_nettype wire

// ===== src/infix_to_postfix_converter_core.sv =====
// Top level of the infix-to-postfix converter: sequencer, operator stack
// memory and output register. Depends on ifp_pkg and the ifp_* modules.
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tdata = symbol, tuser = action
//  m_axis    out  tvalid/tready, tlast   tdata = out_char,
//                                        tuser = {overflow, is_terminator}
//
// An operand's result word goes from the sequencer into the output register.
// An operator pops the entries that yield to it, then is pushed, or for ')'
// drops its '('; end of expression pops every stacked entry, then emits the
// terminator. The single stack read port sets the pace of one pop per cycle
// while the output register is free. One word is taken at a time.
// After reset the stack is empty and the overflow flag clear.
// A stalled output register holds the sequencer until it drains.
`default_nettype none

module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = ifp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire logic       s_axis_tuser_i,   // [0] action
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_char
  output logic [1:0]      m_axis_tuser_o,   // [0] is_terminator, [1] overflow
  output logic            m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic             emit_valid;
  ifp_pkg::result_t emit;
  logic             emit_free;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       top;

  ifp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_end_i    (s_axis_tuser_i),
    .in_symbol_i (s_axis_tdata_i),
    .emit_valid_o(emit_valid),
    .emit_o      (emit),
    .emit_free_i (emit_free),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .top_i       (top)
  );

  ifp_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(top)
  );

  ifp_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_valid_i   (emit_valid),
    .load_i         (emit),
    .free_o         (emit_free),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ===== src/ifp_checker.sv =====
// Port-level checker for the infix-to-postfix core, bound to the top level.
// Depends on infix_to_postfix_converter_core_defines.svh.
`default_nettype none
`include "infix_to_postfix_converter_core_defines.svh"

module ifp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [1:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // A terminator always closes the run of its end-of-expression word.
  `IFP_ASSERT_RUN(a_term_last, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o, "terminator without last")

  `IFP_ASSERT_RUN(a_term_zero, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == 8'h00, "terminator with nonzero char")

  // The core works on one input word at a time.
  `IFP_ASSERT_RUN(a_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input taken while busy")

  // A word waiting for the receiver stays on the bus unchanged.
  `IFP_ASSERT_RUN(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable({m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o}), "output word changed while stalled")

  `IFP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")

endmodule

bind infix_to_postfix_converter_core ifp_checker u_ifp_checker (.*);

`default_nettype wire
